@@ design/sky_region_range_lookup_macros.svh @@
// assertion macros for the sky region range lookup block
// no dependencies; taken in by the modules that carry assertions
`ifndef SKY_REGION_RANGE_LOOKUP_MACROS_SVH
`define SKY_REGION_RANGE_LOOKUP_MACROS_SVH

`ifndef SYNTH

`define SRRL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`define SRRL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SRRL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)

`define SRRL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ design/srrl_pkg.sv @@
// shared types and constants for the sky region range lookup block
// no dependencies
package srrl_pkg;

    localparam int DEC_W    = 23;
    localparam int RA_W     = 24;
    localparam int REGION_W = 7;
    localparam int INDEX_W  = 9;
    localparam int COUNT_W  = 10;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic signed [DEC_W-1:0]    lower_dec;
        logic        [RA_W-1:0]     ra_low;
        logic        [RA_W-1:0]     ra_high;
        logic        [REGION_W-1:0] region;
    } t_entry;

    typedef struct packed {
        logic        [RA_W-1:0]  ra;
        logic signed [DEC_W-1:0] dec;
    } t_query;

    typedef struct packed {
        logic                idle;
        logic                done;
        logic [REGION_W-1:0] region;
    } t_scan_status;

endpackage

@@ design/srrl_table.sv @@
// boundary entry table: one write port, one read port, registered read data
// depends on srrl_pkg
module srrl_table
    import srrl_pkg::*;
#(
    parameter int MAX_ENTRIES = 512,
    localparam int AW = $clog2(MAX_ENTRIES)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_entry,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_entry
);

    t_entry r_mem [MAX_ENTRIES];
    t_entry r_rd_entry;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_entry <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_entry = r_rd_entry;

endmodule

@@ design/srrl_scan.sv @@
// query sequencer: walks the table one entry a cycle, first match wins
// depends on srrl_pkg, srrl_table read timing and the macros header
`include "sky_region_range_lookup_macros.svh"

module srrl_scan
    import srrl_pkg::*;
#(
    parameter int MAX_ENTRIES = 512,
    localparam int AW = $clog2(MAX_ENTRIES),
    localparam int LW = $clog2(MAX_ENTRIES + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_query             i_query,
    input  logic [COUNT_W-1:0] i_count,
    input  logic               i_out_free,
    input  t_entry             i_rd_entry,
    output logic               o_rd_en,
    output logic [AW-1:0]      o_rd_addr,
    output t_scan_status       o_status
);

    localparam int CMPW = (LW > COUNT_W) ? LW : COUNT_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EMIT = 3'b100
    } t_scan_state;

    t_scan_state         r_state, n_state;
    logic [LW-1:0]       r_addr, n_addr;
    logic [LW-1:0]       r_limit, n_limit;
    logic                r_pend, n_pend;
    logic [REGION_W-1:0] r_region, n_region;
    t_query              r_query, n_query;

    logic hit;
    logic issue;

    assign hit = r_pend
        && ($signed(r_query.dec) >= $signed(i_rd_entry.lower_dec))
        && (r_query.ra >= i_rd_entry.ra_low)
        && (r_query.ra <= i_rd_entry.ra_high);

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_limit  = r_limit;
        n_pend   = r_pend;
        n_region = r_region;
        n_query  = r_query;
        issue    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_query = i_query;
                    n_addr  = '0;
                    n_pend  = 1'b0;
                    if (CMPW'(i_count) >= CMPW'(MAX_ENTRIES)) begin
                        n_limit = LW'(MAX_ENTRIES);
                    end else begin
                        n_limit = LW'(i_count);
                    end
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                priority if (hit) begin
                    n_region = i_rd_entry.region;
                    n_pend   = 1'b0;
                    n_state  = S_EMIT;
                end else if (!r_pend && r_addr == r_limit) begin
                    n_region = '0;
                    n_state  = S_EMIT;
                end else begin
                    issue  = (r_addr != r_limit);
                    n_pend = issue;
                    n_addr = r_addr + LW'(issue);
                end
            end
            S_EMIT: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_limit  <= n_limit;
        r_region <= n_region;
        r_query  <= n_query;
    end

    assign o_rd_en          = issue;
    assign o_rd_addr        = r_addr[AW-1:0];
    assign o_status.idle    = (r_state == S_IDLE);
    assign o_status.done    = (r_state == S_EMIT) && i_out_free;
    assign o_status.region  = r_region;

    `SRRL_ASSERT_IMP(a_rd_in_range, i_clk, i_rst_n, o_rd_en, r_addr < r_limit, "read beyond limit")
    `SRRL_ASSERT_IMP(a_addr_bound, i_clk, i_rst_n, r_state == S_SCAN, r_addr <= r_limit, "address past limit")
    `SRRL_ASSERT_IMP(a_start_idle, i_clk, i_rst_n, i_start, r_state == S_IDLE, "start while busy")
    `SRRL_ASSERT_NEXT(a_hit_emit, i_clk, i_rst_n, (r_state == S_SCAN) && hit, (r_state == S_EMIT) && !r_pend, "hit not taken")

endmodule

@@ design/sky_region_range_lookup.sv @@
// sky region range lookup, top level
// depends on srrl_pkg, srrl_table and srrl_scan
//
// Input beats carry either a table write (operation 0) or a position query
// (operation 1), accepted on i_in_valid and o_in_ready. A write stores one
// boundary entry and gives no result; a write whose index is at or
// beyond MAX_ENTRIES is dropped. A query walks the table from entry 0 up
// to min(entry_count, MAX_ENTRIES), one entry per cycle through the single
// read port of the table, and stops at the first match. The sequencer
// registers the query, compares each entry as it leaves the registered
// read port and, on a match or at the end of the walk, enters its emit
// state, from which the result beat enters the output register; the next
// input beat is taken after that. One item is in work at a time. The user
// is to write entry_count only while the block is idle; the config channel
// does not enforce it and is always ready.
// Reset clears the control state and entry_count to 0; table contents stay
// undefined until written. When the receiver stalls, the result is held in
// the output register; a later query then waits with its answer until that
// register frees, while new input beats are taken again once the waiting
// answer has moved into the output register.
module sky_region_range_lookup
    import srrl_pkg::*;
#(
    parameter int MAX_ENTRIES = 512
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_operation,
    input  logic [INDEX_W-1:0]         i_entry_index,
    input  logic signed [DEC_W-1:0]    i_entry_lower_dec,
    input  logic [RA_W-1:0]            i_entry_ra_low,
    input  logic [RA_W-1:0]            i_entry_ra_high,
    input  logic [REGION_W-1:0]        i_entry_region,
    input  logic [RA_W-1:0]            i_query_ra,
    input  logic signed [DEC_W-1:0]    i_query_dec,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [REGION_W-1:0]        o_region_number,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [COUNT_W-1:0]         i_cfg_data
);

    localparam int AW = $clog2(MAX_ENTRIES);

    logic [COUNT_W-1:0]  r_entry_count;
    logic                r_out_valid;
    logic [REGION_W-1:0] r_region;

    logic          in_beat;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_entry;
    logic          start;
    t_query        query;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_entry        rd_entry;
    t_scan_status  status;
    logic          out_free;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = status.idle;
    assign in_beat     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    assign wr_en = in_beat && (i_operation == OP_WRITE)
        && (32'(i_entry_index) < 32'(MAX_ENTRIES));
    assign wr_addr            = AW'(i_entry_index);
    assign wr_entry.lower_dec = i_entry_lower_dec;
    assign wr_entry.ra_low    = i_entry_ra_low;
    assign wr_entry.ra_high   = i_entry_ra_high;
    assign wr_entry.region    = i_entry_region;

    assign start    = in_beat && (i_operation == OP_QUERY);
    assign query.ra  = i_query_ra;
    assign query.dec = i_query_dec;

    srrl_table #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_table (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_entry (wr_entry),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_entry (rd_entry)
    );

    srrl_scan #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_query    (query),
        .i_count    (r_entry_count),
        .i_out_free (out_free),
        .i_rd_entry (rd_entry),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .o_status   (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_entry_count <= i_cfg_data;
            end
            if (status.done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (status.done) begin
            r_region <= status.region;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_region_number = r_region;

endmodule

@@ tb/region_check_pkg.sv @@
`timescale 1ns / 1ps
// scoreboard for the sky region range lookup testbench: predicted boundary table,
// entry count and the queue of region numbers still owed by the block
// depends on srrl_pkg
package region_check_pkg;
    import srrl_pkg::*;

    localparam int TABLE_DEPTH = 512;

    class region_scoreboard;
        logic signed [DEC_W-1:0] lower_dec_tab [TABLE_DEPTH];
        logic [RA_W-1:0]         ra_low_tab [TABLE_DEPTH];
        logic [RA_W-1:0]         ra_high_tab [TABLE_DEPTH];
        logic [REGION_W-1:0]     region_tab [TABLE_DEPTH];
        logic [COUNT_W-1:0]      entry_count;
        logic [REGION_W-1:0]     expected_regions [$];
        int errors;
        int writes;
        int queries;
        int hits;

        function new();
            entry_count = '0;
            errors = 0;
            writes = 0;
            queries = 0;
            hits = 0;
        endfunction

        function void set_count(logic [COUNT_W-1:0] value);
            entry_count = value;
        endfunction

        // first entry whose lower dec and inclusive ra interval hold the position
        function logic [REGION_W-1:0] lookup_region(logic [RA_W-1:0] ra,
                                                   logic signed [DEC_W-1:0] dec);
            int span;
            bit matched;
            logic [REGION_W-1:0] found;
            span = (int'(entry_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
            found = '0;
            matched = 1'b0;
            for (int k = 0; k < span && !matched; k++) begin
                if (dec >= lower_dec_tab[k] && ra >= ra_low_tab[k] && ra <= ra_high_tab[k]) begin
                    found = region_tab[k];
                    matched = 1'b1;
                end
            end
            return found;
        endfunction

        function void accept_beat(logic op, logic [INDEX_W-1:0] idx,
                                  logic signed [DEC_W-1:0] lower_dec,
                                  logic [RA_W-1:0] ra_low, logic [RA_W-1:0] ra_high,
                                  logic [REGION_W-1:0] region,
                                  logic [RA_W-1:0] query_ra,
                                  logic signed [DEC_W-1:0] query_dec);
            logic [REGION_W-1:0] answer;
            if (op == OP_WRITE) begin
                if (int'(idx) < TABLE_DEPTH) begin
                    lower_dec_tab[idx] = lower_dec;
                    ra_low_tab[idx] = ra_low;
                    ra_high_tab[idx] = ra_high;
                    region_tab[idx] = region;
                end
                writes++;
            end else begin
                answer = lookup_region(query_ra, query_dec);
                expected_regions.push_back(answer);
                queries++;
                if (answer != '0) hits++;
            end
        endfunction

        function void check_region(logic [REGION_W-1:0] got);
            logic [REGION_W-1:0] want;
            if (expected_regions.size() == 0) begin
                $error("region_number: result beat with nothing expected, got %0d", got);
                errors++;
            end else begin
                want = expected_regions.pop_front();
                if (got !== want) begin
                    $error("region_number: expected %0d, got %0d", want, got);
                    errors++;
                end
            end
        endfunction
    endclass

endpackage

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// top of the sky region range lookup testbench: table writes, position queries and
// entry count settings with random gaps and stalls, every region number scoreboarded
// depends on srrl_pkg, region_check_pkg and the sky_region_range_lookup RTL
module tb;
    import srrl_pkg::*;
    import region_check_pkg::*;

    localparam int TOTAL_BEATS = 950;
    localparam int SETTLE      = 16;
    localparam int MAX_GAP     = 8;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int RA_MAX      = 12960000;
    localparam int DEC_MAX     = 3240000;
    localparam int DEC_TOP     = (1 << (DEC_W - 1)) - 1;
    localparam int COUNT_TOP   = (1 << COUNT_W) - 1;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic                    i_operation = OP_WRITE;
    logic [INDEX_W-1:0]      i_entry_index = '0;
    logic signed [DEC_W-1:0] i_entry_lower_dec = '0;
    logic [RA_W-1:0]         i_entry_ra_low = '0;
    logic [RA_W-1:0]         i_entry_ra_high = '0;
    logic [REGION_W-1:0]     i_entry_region = '0;
    logic [RA_W-1:0]         i_query_ra = '0;
    logic signed [DEC_W-1:0] i_query_dec = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [REGION_W-1:0]     o_region_number;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [COUNT_W-1:0]      i_cfg_data = '0;

    region_scoreboard sb = new();

    bit slot_loaded [TABLE_DEPTH];
    int loaded_prefix = 0;
    int beats_sent = 0;
    int counts_written = 0;
    int top_count = 0;
    int cycles = 0;
    bit in_gapless = 1'b0;
    bit out_gapless = 1'b0;

    sky_region_range_lookup #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_operation       (i_operation),
        .i_entry_index     (i_entry_index),
        .i_entry_lower_dec (i_entry_lower_dec),
        .i_entry_ra_low    (i_entry_ra_low),
        .i_entry_ra_high   (i_entry_ra_high),
        .i_entry_region    (i_entry_region),
        .i_query_ra        (i_query_ra),
        .i_query_dec       (i_query_dec),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_region_number   (o_region_number),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    task automatic send_beat(input logic op, input logic [INDEX_W-1:0] idx,
                             input logic signed [DEC_W-1:0] lower_dec,
                             input logic [RA_W-1:0] ra_low, input logic [RA_W-1:0] ra_high,
                             input logic [REGION_W-1:0] region,
                             input logic [RA_W-1:0] query_ra,
                             input logic signed [DEC_W-1:0] query_dec);
        int gap;
        gap = in_gapless ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_entry_index <= idx;
        i_entry_lower_dec <= lower_dec;
        i_entry_ra_low <= ra_low;
        i_entry_ra_high <= ra_high;
        i_entry_region <= region;
        i_query_ra <= query_ra;
        i_query_dec <= query_dec;
        do @(posedge i_clk); while (!o_in_ready);
        sb.accept_beat(op, idx, lower_dec, ra_low, ra_high, region, query_ra, query_dec);
        beats_sent++;
    endtask

    task automatic write_entry(input logic [INDEX_W-1:0] idx,
                               input logic signed [DEC_W-1:0] lower_dec,
                               input logic [RA_W-1:0] ra_low, input logic [RA_W-1:0] ra_high,
                               input logic [REGION_W-1:0] region);
        send_beat(OP_WRITE, idx, lower_dec, ra_low, ra_high, region,
                  RA_W'($urandom), DEC_W'($urandom));
        slot_loaded[idx] = 1'b1;
        while (loaded_prefix < TABLE_DEPTH && slot_loaded[loaded_prefix]) loaded_prefix++;
    endtask

    task automatic ask_position(input logic [RA_W-1:0] ra, input logic signed [DEC_W-1:0] dec);
        send_beat(OP_QUERY, INDEX_W'($urandom), DEC_W'($urandom), RA_W'($urandom),
                  RA_W'($urandom), REGION_W'($urandom), ra, dec);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.expected_regions.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [COUNT_W-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_count(value);
        i_cfg_valid <= 1'b0;
        counts_written++;
        if (int'(value) > top_count) top_count = int'(value);
    endtask

    task automatic rand_write(input logic [INDEX_W-1:0] idx);
        logic signed [DEC_W-1:0] lower_dec;
        logic [RA_W-1:0] ra_low;
        logic [RA_W-1:0] ra_high;
        logic [REGION_W-1:0] region;
        int lo;
        int w;
        case ($urandom_range(0, 9))
            0: lower_dec = DEC_W'(-DEC_MAX);
            1: lower_dec = DEC_W'(DEC_MAX);
            2: lower_dec = DEC_W'($urandom);
            default: lower_dec = DEC_W'(int'($urandom_range(0, 2 * DEC_MAX)) - DEC_MAX);
        endcase
        case ($urandom_range(0, 9))
            0: begin
                ra_low = RA_W'($urandom);
                ra_high = RA_W'($urandom);
            end
            1: begin
                ra_high = RA_W'($urandom_range(0, RA_MAX - 1));
                ra_low = RA_W'($urandom_range(int'(ra_high) + 1, RA_MAX));
            end
            2: begin
                ra_low = '0;
                ra_high = RA_W'(RA_MAX);
            end
            default: begin
                lo = $urandom_range(0, RA_MAX);
                case ($urandom_range(0, 2))
                    0: w = $urandom_range(0, 100);
                    1: w = $urandom_range(0, 100000);
                    default: w = $urandom_range(0, 3000000);
                endcase
                ra_low = RA_W'(lo);
                ra_high = RA_W'((lo + w > RA_MAX) ? RA_MAX : lo + w);
            end
        endcase
        case ($urandom_range(0, 9))
            0: region = '0;
            1: region = REGION_W'($urandom_range(89, 127));
            default: region = REGION_W'($urandom_range(1, 88));
        endcase
        write_entry(idx, lower_dec, ra_low, ra_high, region);
    endtask

    // mostly aim at a scanned entry, on and just past its edges
    task automatic rand_query(input int n);
        int k;
        int lo;
        int hi;
        int floor_dec;
        int ra;
        int dec;
        if (n > 0 && $urandom_range(0, 9) < 6) begin
            k = $urandom_range(0, n - 1);
            lo = int'(sb.ra_low_tab[k]);
            hi = int'(sb.ra_high_tab[k]);
            floor_dec = int'(sb.lower_dec_tab[k]);
            if (lo <= hi) begin
                case ($urandom_range(0, 4))
                    0: ra = lo;
                    1: ra = hi;
                    2: ra = hi + 1;
                    3: ra = lo - 1;
                    default: ra = $urandom_range(lo, hi);
                endcase
            end else begin
                ra = $urandom_range(0, RA_MAX);
            end
            case ($urandom_range(0, 3))
                0: dec = floor_dec;
                1: dec = floor_dec - 1;
                default: dec = floor_dec + int'($urandom_range(0, 200000));
            endcase
            if (dec > DEC_TOP) dec = DEC_TOP;
            if (dec < -DEC_TOP - 1) dec = -DEC_TOP - 1;
            ask_position(RA_W'(ra), DEC_W'(dec));
        end else begin
            ask_position(($urandom_range(0, 2) == 0) ? RA_W'($urandom)
                                                     : RA_W'($urandom_range(0, RA_MAX)),
                         ($urandom_range(0, 2) == 0) ? DEC_W'($urandom)
                                : DEC_W'(int'($urandom_range(0, 2 * DEC_MAX)) - DEC_MAX));
        end
    endtask

    // never scan past the run of loaded slots, except once the table is full
    function automatic logic [COUNT_W-1:0] pick_count();
        int top;
        int c;
        top = (loaded_prefix < 24) ? loaded_prefix : 24;
        if (loaded_prefix == TABLE_DEPTH) begin
            case ($urandom_range(0, 9))
                0: c = 0;
                1: c = TABLE_DEPTH;
                2: c = $urandom_range(TABLE_DEPTH + 1, COUNT_TOP);
                3: c = $urandom_range(25, TABLE_DEPTH);
                default: c = $urandom_range(1, 24);
            endcase
        end else begin
            case ($urandom_range(0, 5))
                0: c = 0;
                1: c = loaded_prefix;
                default: c = $urandom_range(0, top);
            endcase
        end
        return COUNT_W'(c);
    endfunction

    initial begin : result_sink
        int gap;
        forever begin
            gap = out_gapless ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_rst_n));
            sb.check_region(o_region_number);
        end
    end

    initial begin : main_seq
        int phase;
        int n;
        int pick;
        logic [COUNT_W-1:0] count;
        logic [INDEX_W-1:0] idx;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // count still at reset value: empty scan
        ask_position(24'd1500, 23'sd0);
        write_entry(9'd0, 23'sd0, 24'd1000, 24'd2000, 7'd1);
        write_entry(9'd1, -23'sd3240000, 24'd0, 24'd0, 7'd88);
        write_entry(9'd2, 23'sd3240000, 24'd12960000, 24'd12960000, 7'd127);
        write_entry(9'd3, -23'sd3240000, 24'd5000, 24'd4000, 7'd5);
        write_entry(9'd4, -23'sd3240000, 24'd6000, 24'd7000, 7'd0);
        write_entry(9'd5, -23'sd3240000, 24'd0, 24'd12960000, 7'd42);
        write_entry(9'd511, -23'sd4194304, 24'd0, 24'hFFFFFF, 7'h7F);
        write_count(10'd6);
        ask_position(24'd1500, 23'sd0);
        ask_position(24'd1000, 23'sd10);
        ask_position(24'd2000, 23'sd3240000);
        ask_position(24'd2001, 23'sd0);
        ask_position(24'd0, -23'sd3240000);
        ask_position(24'd12960000, 23'sd3240000);
        ask_position(24'd12960000, 23'sd3239999);
        ask_position(24'd4500, 23'sd0);
        ask_position(24'd6500, 23'sd0);
        ask_position(24'd1500, -23'sd1);
        ask_position(24'hFFFFFF, 23'sd4194303);
        ask_position(24'd0, -23'sd4194304);
        write_count(10'd3);
        ask_position(24'd7000, 23'sd0);
        write_count(10'd0);
        ask_position(24'd1500, 23'sd0);

        phase = 0;
        while (beats_sent < TOTAL_BEATS) begin
            phase++;
            in_gapless = ($urandom_range(0, 4) == 0);
            out_gapless = ($urandom_range(0, 4) == 0);
            if (phase == 5) begin
                for (int k = 0; k < TABLE_DEPTH; k++) begin
                    if (!slot_loaded[k]) rand_write(INDEX_W'(k));
                end
            end
            if (phase == 6 && loaded_prefix == TABLE_DEPTH) count = COUNT_W'(COUNT_TOP);
            else if (phase == 7 && loaded_prefix == TABLE_DEPTH) count = COUNT_W'(TABLE_DEPTH);
            else count = pick_count();
            write_count(count);
            n = (int'(count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(count);
            repeat ($urandom_range(20, 60)) begin
                if ($urandom_range(0, 99) < 45) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 4 && loaded_prefix < TABLE_DEPTH) idx = INDEX_W'(loaded_prefix);
                    else if (pick < 8 && n > 0) idx = INDEX_W'($urandom_range(0, n - 1));
                    else idx = INDEX_W'($urandom_range(0, TABLE_DEPTH - 1));
                    rand_write(idx);
                end else begin
                    rand_query(n);
                end
            end
        end

        wait_drained();
        $display("covered %0d table writes and %0d queries, %0d answered with a nonzero region",
                 sb.writes, sb.queries, sb.hits);
        $display("entry count written %0d times over %0d phases, largest setting %0d",
                 counts_written, phase, top_count);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
